// File: rtl/core/csma_pkg.sv
// types and constants shared by the csma transmit backoff controller
package csma_pkg;

	localparam int TIME_BITS   = 32;
	localparam int RANDOM_BITS = 16;
	localparam int CFG_IDX_BITS = 2;

	typedef enum logic [1:0] {
		ST_OFF       = 2'd0,
		ST_WAIT      = 2'd1,
		ST_SWITCHING = 2'd2,
		ST_FINISHED  = 2'd3
	} state_t;

	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_RX   = 2'd1,
		CMD_TX   = 2'd2
	} radio_cmd_t;

	typedef enum logic [2:0] {
		OP_START    = 3'd0,
		OP_RX_READY = 3'd1,
		OP_TIMER    = 3'd2,
		OP_TX_READY = 3'd3,
		OP_SENSE    = 3'd4
	} opcode_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_BACKOFF_MODE = 2'd0,
		REG_MIN_BACKOFF  = 2'd1,
		REG_MAX_BACKOFF  = 2'd2,
		REG_MIN_CW       = 2'd3
	} cfg_reg_t;

	localparam logic [TIME_BITS-1:0] MAX_BACKOFF_RST = TIME_BITS'(1000);
	localparam logic [TIME_BITS-1:0] MIN_CW_RST      = TIME_BITS'(10);
	localparam logic [TIME_BITS-1:0] TIME_MAX        = {TIME_BITS{1'b1}};

endpackage

// File: rtl/core/csma_tx_backoff_controller.sv
// csma transmit backoff controller: event handling, carrier sense and backoff draw
//
// usage: one request on the in channel carries an event (opcode) with the carrier
// status, a 16-bit random fraction and a delay window; each request gives exactly
// one result on the out channel with the new state, a radio mode command and,
// when the carrier is busy, the backoff delay to load into an external timer.
// channels use valid/stall: a request moves at a clock edge with valid high and
// stall low. configuration registers are written over cfg (valid/ready, ready
// is always high); the user must write them only while no request is in flight,
// the block does not enforce it. a request taken sits in the input register, is
// evaluated there and moves into the result register when that register can
// advance. throughput: one request per cycle while out_stall stays low; the
// evaluation (one 32x16 multiply plus the saturating total update) is combinational.
// a stalled result holds in the result register while the input register still
// fills; in_stall rises only when both registers are occupied.
// reset: state goes to off, accumulated backoff to zero, registers to defaults.
module csma_tx_backoff_controller
	import csma_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [TIME_BITS-1:0]    cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [2:0]              opcode,
	input  logic                    rx_idle,
	input  logic                    radio_listening,
	input  logic                    timer_pending,
	input  logic [RANDOM_BITS-1:0]  random_value,
	input  logic [TIME_BITS-1:0]    window_low,
	input  logic [TIME_BITS-1:0]    window_high,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              ctrl_state,
	output logic [1:0]              radio_command,
	output logic                    schedule_timer,
	output logic [TIME_BITS-1:0]    delay_ticks,
	output logic                    aborted
);

	// configuration
	logic                 backoff_mode_q;
	logic [TIME_BITS-1:0] min_backoff_q;
	logic [TIME_BITS-1:0] max_backoff_q;
	logic [TIME_BITS-1:0] min_cw_q;

	// controller state
	state_t               state_q;
	logic [TIME_BITS-1:0] total_q;

	// input register
	logic                   valid_s1;
	logic [2:0]             opcode_s1;
	logic                   rx_idle_s1;
	logic                   listening_s1;
	logic                   pending_s1;
	logic [RANDOM_BITS-1:0] random_s1;
	logic [TIME_BITS-1:0]   wlo_s1;
	logic [TIME_BITS-1:0]   whi_s1;

	// result register
	logic                 out_valid_q;
	state_t               res_state_q;
	radio_cmd_t           res_cmd_q;
	logic                 res_sched_q;
	logic [TIME_BITS-1:0] res_delay_q;
	logic                 res_abort_q;

	logic advance;
	logic take_in;

	// evaluation results
	state_t                           state_d;
	radio_cmd_t                       cmd_d;
	logic                             sched_d;
	logic [TIME_BITS-1:0]             delay_d;
	logic                             abort_d;
	logic [TIME_BITS-1:0]             total_d;
	logic                             sense;
	logic                             given;
	logic [TIME_BITS-1:0]             rem;
	logic [TIME_BITS-1:0]             win;
	logic [TIME_BITS-1:0]             lo;
	logic [TIME_BITS-1:0]             hi;
	logic [TIME_BITS-1:0]             span;
	logic [TIME_BITS+RANDOM_BITS-1:0] prod;
	logic [TIME_BITS-1:0]             drawn;
	logic [TIME_BITS:0]               sum;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign take_in   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backoff_mode_q <= 1'b0;
			min_backoff_q  <= '0;
			max_backoff_q  <= MAX_BACKOFF_RST;
			min_cw_q       <= MIN_CW_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BACKOFF_MODE: backoff_mode_q <= cfg_data[0];
				REG_MIN_BACKOFF:  min_backoff_q  <= cfg_data;
				REG_MAX_BACKOFF:  max_backoff_q  <= cfg_data;
				REG_MIN_CW:       min_cw_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			opcode_s1    <= opcode;
			rx_idle_s1   <= rx_idle;
			listening_s1 <= radio_listening;
			pending_s1   <= timer_pending;
			random_s1    <= random_value;
			wlo_s1       <= window_low;
			whi_s1       <= window_high;
		end
	end

	// event decode and backoff draw
	always_comb begin
		state_d = state_q;
		cmd_d   = CMD_NONE;
		sched_d = 1'b0;
		delay_d = '0;
		abort_d = 1'b0;
		sense   = 1'b0;
		given   = 1'b0;

		if (opcode_t'(opcode_s1) == OP_SENSE) begin
			sense = 1'b1;
			given = 1'b1;
		end else begin
			unique case (state_q)
				ST_OFF: begin
					if (opcode_t'(opcode_s1) == OP_START) begin
						cmd_d   = CMD_RX;
						state_d = ST_WAIT;
					end
				end
				ST_WAIT: begin
					if ((opcode_t'(opcode_s1) == OP_RX_READY ||
					     opcode_t'(opcode_s1) == OP_TIMER) && !pending_s1) begin
						sense = 1'b1;
					end
				end
				ST_SWITCHING: begin
					if (opcode_t'(opcode_s1) == OP_TX_READY) begin
						state_d = ST_FINISHED;
					end
				end
				ST_FINISHED: ;
				default: ;
			endcase
		end

		rem = (max_backoff_q > total_q) ? (max_backoff_q - total_q) : '0;
		win = rem >> 1;

		priority if (given) begin
			lo = wlo_s1;
			hi = whi_s1;
		end else if (!backoff_mode_q) begin
			lo = min_backoff_q;
			hi = max_backoff_q;
		end else begin
			lo = '0;
			hi = win;
		end

		span  = (hi > lo) ? (hi - lo) : '0;
		prod  = {{RANDOM_BITS{1'b0}}, span} * {{TIME_BITS{1'b0}}, random_s1};
		drawn = lo + prod[TIME_BITS+RANDOM_BITS-1:RANDOM_BITS];

		if (sense) begin
			if (rx_idle_s1 && listening_s1) begin
				cmd_d   = CMD_TX;
				state_d = ST_SWITCHING;
			end else if (!given && backoff_mode_q && !(win > min_cw_q)) begin
				abort_d = 1'b1;
				state_d = ST_OFF;
			end else begin
				delay_d = drawn;
				sched_d = 1'b1;
				state_d = ST_WAIT;
			end
		end

		sum     = {1'b0, total_q} + {1'b0, delay_d};
		total_d = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_OFF;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_d;
				total_q <= total_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_state_q <= state_d;
			res_cmd_q   <= cmd_d;
			res_sched_q <= sched_d;
			res_delay_q <= delay_d;
			res_abort_q <= abort_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign ctrl_state     = res_state_q;
	assign radio_command  = res_cmd_q;
	assign schedule_timer = res_sched_q;
	assign delay_ticks    = res_delay_q;
	assign aborted        = res_abort_q;

endmodule

// File: rtl/core/csma_chk.sv
// port-level checker for the csma transmit backoff controller, with its bind
module csma_chk
	import csma_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [1:0]           ctrl_state,
	input logic [1:0]           radio_command,
	input logic                 schedule_timer,
	input logic [TIME_BITS-1:0] delay_ticks,
	input logic                 aborted
);

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// an abort leaves the controller off with nothing scheduled
	a_abort_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && aborted |->
			ctrl_state == ST_OFF && !schedule_timer && delay_ticks == '0 &&
			radio_command == CMD_NONE)
		else $error("abort result inconsistent");

	// a scheduled backoff always returns to wait without a radio command
	a_sched_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && schedule_timer |-> ctrl_state == ST_WAIT && radio_command == CMD_NONE)
		else $error("backoff scheduled outside wait");

	// transmitter mode is only asked when entering switching
	a_tx_switch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && radio_command == CMD_TX |-> ctrl_state == ST_SWITCHING)
		else $error("tx command without switching");

	// no delay reported without a timer request
	a_delay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !schedule_timer |-> delay_ticks == '0)
		else $error("delay without timer request");

endmodule

bind csma_tx_backoff_controller csma_chk u_csma_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.ctrl_state     (ctrl_state),
	.radio_command  (radio_command),
	.schedule_timer (schedule_timer),
	.delay_ticks    (delay_ticks),
	.aborted        (aborted)
);
